FILE: rtl/core/hpt_pkg.sv
package hpt_pkg;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_POINT = 2'd1;
	localparam logic [1:0] OP_DIR = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [1:0] row_index;
		logic [1:0] col_index;
		logic signed [31:0] entry_value;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic was_divided;
		logic saturated;
	} out_item_t;

	// Work item handed from the front end to the back end through the queue.
	typedef struct packed {
		logic is_point;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
	} job_t;

endpackage

FILE: rtl/core/hpt_front.sv
module hpt_front #(
	parameter int FRAC_BITS = 16,
	parameter int QDEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input hpt_pkg::in_item_t in_data,
	output logic [16*32-1:0] mat_flat,
	output logic job_valid,
	input logic job_ready,
	output hpt_pkg::job_t job_data
);
	import hpt_pkg::*;

	localparam int QW = $clog2(QDEPTH);

	logic [31:0] mat_q [16];
	job_t queue_q [QDEPTH];
	logic [QW-1:0] wptr_q, rptr_q;
	logic [QW:0] count_q;
	logic is_job, push, pop;
	logic [3:0] idx;

	// A load must not reach the matrix while a queued job still reads it.
	assign is_job = (in_data.opcode == OP_POINT) || (in_data.opcode == OP_DIR);
	assign in_ready = is_job ? (count_q != QDEPTH[QW:0])
		: ((in_data.opcode != OP_LOAD) || (count_q == '0));
	assign push = in_valid && in_ready && is_job;
	assign pop = job_valid && job_ready;
	assign job_valid = (count_q != '0);
	assign job_data = queue_q[rptr_q];
	assign idx = {in_data.row_index, in_data.col_index};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				mat_q[i] <= ((i >> 2) == (i & 3)) ? (32'd1 << FRAC_BITS) : 32'd0;
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (in_valid && in_ready && in_data.opcode == OP_LOAD)
				mat_q[idx] <= in_data.entry_value;
			if (push) begin
				queue_q[wptr_q] <= '{is_point: in_data.opcode == OP_POINT,
					vx: in_data.vx, vy: in_data.vy, vz: in_data.vz};
				wptr_q <= (wptr_q == QW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop)
				rptr_q <= (rptr_q == QW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			count_q <= count_q + (QW+1)'(push) - (QW+1)'(pop);
		end
	end

	always_comb begin
		for (int i = 0; i < 16; i++)
			mat_flat[i*32 +: 32] = mat_q[i];
	end
endmodule

FILE: rtl/core/hpt_back.sv
module hpt_back #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic [16*32-1:0] mat_flat,
	input logic job_valid,
	output logic job_ready,
	input hpt_pkg::job_t job_data,
	output logic busy,
	output logic out_valid,
	input logic out_ready,
	output hpt_pkg::out_item_t out_data
);
	import hpt_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MAC = 3'd1;
	localparam logic [2:0] ST_CLIP = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_QUOT = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;
	localparam int NW = 32 + FRAC_BITS + 1;   // dividend magnitude width
	localparam int AW = 66 - FRAC_BITS;       // exact width of a row sum

	logic [2:0] state_q;
	job_t job_q;
	logic [1:0] row_q, col_q, drow_q;
	logic signed [AW-1:0] acc_q [4];
	logic signed [31:0] res_q [4];
	logic sat_q, div_q;
	logic signed [63:0] prod_q;
	logic prod_v_q;
	logic [1:0] prow_q;
	logic [5:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [32:0] rem_q, den_q;
	logic neg_q;

	logic signed [31:0] m_sel, v_sel;
	logic signed [63:0] ptr;
	logic signed [AW-1:0] acc_c;
	logic signed [AW-1:0] sum_c [4];
	logic signed [31:0] sclip_c [4];
	logic [3:0] ssat_c;
	logic signed [31:0] clip_c;
	logic clip_sat;
	logic [33:0] trial;
	logic [NW-1:0] qmag;
	logic signed [NW:0] qs;
	logic [31:0] wabs;
	logic signed [NW:0] nsig;

	always_comb begin
		m_sel = mat_flat[{row_q, col_q}*32 +: 32];
		unique case (col_q)
			2'd0: v_sel = job_q.vx;
			2'd1: v_sel = job_q.vy;
			default: v_sel = job_q.vz;
		endcase
		ptr = prod_q >>> FRAC_BITS;
	end

	// Row sums, with the translation column for a point, clipped to 32 bits.
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			sum_c[r] = acc_q[r] + (job_q.is_point ?
				AW'(signed'(mat_flat[{2'(r), 2'd3}*32 +: 32])) : AW'(0));
			ssat_c[r] = (sum_c[r][AW-1:31] != '0) && (sum_c[r][AW-1:31] != '1);
			sclip_c[r] = ssat_c[r] ? (sum_c[r][AW-1] ? 32'sh80000000 : 32'sh7fffffff)
				: sum_c[r][31:0];
		end
	end

	assign job_ready = (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data = '{rx: res_q[0], ry: res_q[1], rz: res_q[2],
		was_divided: div_q, saturated: sat_q};
	assign trial = {rem_q, num_q[NW-1]} - {1'b0, den_q};
	assign wabs = res_q[3][31] ? 32'(-res_q[3]) : res_q[3];

	always_comb begin
		nsig = (NW+1)'(signed'(res_q[drow_q])) <<< FRAC_BITS;
		qmag = num_q;
		qs = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
		clip_sat = 1'b0;
		clip_c = 32'sd0;
		if (qs > (NW+1)'(33'sd2147483647)) begin
			clip_sat = 1'b1; clip_c = 32'sh7fffffff;
		end else if (qs < -(NW+1)'(33'sd2147483648)) begin
			clip_sat = 1'b1; clip_c = 32'sh80000000;
		end else
			clip_c = qs[31:0];
		acc_c = acc_q[prow_q] + AW'(ptr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prod_v_q <= 1'b0;
		end else begin
			// Multiply stage registered; the product is accumulated in the next cycle.
			prod_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (job_valid) begin
					job_q <= job_data;
					row_q <= job_data.is_point ? 2'd3 : 2'd0;
					col_q <= '0;
					for (int i = 0; i < 4; i++) acc_q[i] <= '0;
					sat_q <= 1'b0;
					div_q <= 1'b0;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					prod_q <= m_sel * v_sel;
					prod_v_q <= 1'b1;
					prow_q <= row_q;
					if (col_q == 2'd2) begin
						col_q <= '0;
						if (row_q == 2'd2) state_q <= ST_CLIP;
						else row_q <= (row_q == 2'd3) ? 2'd0 : row_q + 1'b1;
					end else col_q <= col_q + 1'b1;
				end
				ST_CLIP: if (!prod_v_q) begin
					// The last product reaches its accumulator in the cycle before.
					drow_q <= 2'd0;
					for (int r = 0; r < 4; r++)
						res_q[r] <= sclip_c[r];
					if ((|ssat_c[2:0]) || (job_q.is_point && ssat_c[3])) sat_q <= 1'b1;
					state_q <= job_q.is_point ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					if (res_q[3] == 32'sd0 || res_q[3] == (32'sd1 <<< FRAC_BITS))
						state_q <= ST_OUT;
					else begin
						div_q <= 1'b1;
						num_q <= nsig[NW] ? NW'(-nsig) : NW'(nsig);
						neg_q <= nsig[NW] ^ res_q[3][31];
						den_q <= {1'b0, wabs};
						rem_q <= '0;
						cnt_q <= 6'(NW);
						state_q <= ST_QUOT;
					end
				end
				ST_QUOT: begin
					if (cnt_q != '0) begin
						if (!trial[33]) begin
							rem_q <= trial[32:0];
							num_q <= {num_q[NW-2:0], 1'b1};
						end else begin
							rem_q <= {rem_q[31:0], num_q[NW-1]};
							num_q <= {num_q[NW-2:0], 1'b0};
						end
						cnt_q <= cnt_q - 1'b1;
					end else begin
						res_q[drow_q] <= clip_c;
						if (clip_sat) sat_q <= 1'b1;
						if (drow_q == 2'd2) state_q <= ST_OUT;
						else begin
							drow_q <= drow_q + 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (prod_v_q) acc_q[prow_q] <= acc_c;
		end
	end
endmodule

FILE: rtl/core/homogeneous_point_transform.sv
// Homogeneous 4x4 point and direction transform, signed fixed point.
// Each item passes through the job queue, the multiply-accumulate and the clip; a point
// whose w is neither zero nor one then goes through the perspective divide.
// The back end works on one item at a time and takes the next queued job only after the
// result has left; output stalls hold the result.
// Reset: arst_n clears control state and loads the identity matrix.
module homogeneous_point_transform #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input hpt_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output hpt_pkg::out_item_t out_data
);
	import hpt_pkg::*;

	// The front end holds the matrix and a two-entry job queue; loads wait
	// until the queue and the back end are drained so a transfer never sees
	// a half-updated matrix.
	logic [16*32-1:0] mat_flat;
	logic job_valid, job_ready, busy, fe_ready;
	job_t job_data;

	assign in_ready = fe_ready && !(in_data.opcode == OP_LOAD && busy);

	hpt_front #(.FRAC_BITS(FRAC_BITS), .QDEPTH(2)) u_front (
		.clk, .arst_n, .in_valid(in_valid && in_ready), .in_ready(fe_ready),
		.in_data, .mat_flat, .job_valid, .job_ready, .job_data);

	// The back end accumulates three rows (four for a point) with one registered multiplier,
	// clips, then for a point runs a restoring divider once per component unless w is zero or one.
	hpt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .mat_flat, .job_valid, .job_ready, .job_data, .busy,
		.out_valid, .out_ready, .out_data);

`ifndef SYNTHESIS
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.opcode == OP_LOAD |-> !busy && !job_valid)
		else $error("load while work pending");
	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_ready |-> !out_valid)
		else $error("result offered while the back end is idle");
`endif
endmodule

FILE: bench/tb_top.sv
module tb_top;
	import hpt_pkg::*;

	localparam int FRAC = 16;
	localparam int N_RANDOM = 400;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;

	// Scoreboard: holds its own copy of the matrix and the queue of predicted
	// transform results, in the order the block must return them.
	class transform_scoreboard;
		logic signed [31:0] mat [16];
		out_item_t predicted [$];
		int errors;

		function new();
			errors = 0;
			for (int i = 0; i < 16; i++) begin
				mat[i] = ((i >> 2) == (i & 3)) ? ONE : 32'sd0;
			end
		endfunction

		// Fixed-point product, truncated toward minus infinity.
		function automatic logic signed [63:0] fx_mul(logic signed [31:0] a,
				logic signed [31:0] b);
			logic signed [63:0] p;
			p = 64'(a) * 64'(b);
			return p >>> FRAC;
		endfunction

		function automatic logic signed [31:0] clip(logic signed [63:0] v, ref bit sat);
			if (v > 64'sd2147483647) begin
				sat = 1;
				return 32'sh7fff_ffff;
			end
			if (v < -64'sd2147483648) begin
				sat = 1;
				return 32'sh8000_0000;
			end
			return v[31:0];
		endfunction

		function automatic logic signed [63:0] row_dot(int r, in_item_t it, bit affine);
			logic signed [63:0] s;
			s = fx_mul(mat[r*4], it.vx) + fx_mul(mat[r*4+1], it.vy)
				+ fx_mul(mat[r*4+2], it.vz);
			if (affine) begin
				s += 64'(mat[r*4+3]);
			end
			return s;
		endfunction

		// Notes one accepted input transfer: updates the matrix or predicts.
		function void note_input(in_item_t it);
			out_item_t o;
			bit sat;
			logic signed [31:0] w;
			logic signed [31:0] c [3];
			logic signed [63:0] q;
			sat = 0;
			o = '0;
			if (it.opcode == OP_LOAD) begin
				mat[{it.row_index, it.col_index}] = it.entry_value;
				return;
			end
			if (it.opcode == OP_UNUSED) begin
				return;
			end
			if (it.opcode == OP_POINT) begin
				w = clip(row_dot(3, it, 1), sat);
				for (int r = 0; r < 3; r++) begin
					c[r] = clip(row_dot(r, it, 1), sat);
				end
				// Perspective divide is skipped when w is zero or exactly one.
				if (w != 0 && w != ONE) begin
					o.was_divided = 1;
					for (int r = 0; r < 3; r++) begin
						q = (64'(c[r]) <<< FRAC) / 64'(w);
						c[r] = clip(q, sat);
					end
				end
			end else begin
				for (int r = 0; r < 3; r++) begin
					c[r] = clip(row_dot(r, it, 0), sat);
				end
			end
			o.rx = c[0];
			o.ry = c[1];
			o.rz = c[2];
			o.saturated = sat;
			predicted.push_back(o);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] exp_v);
			$display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $time);
			errors++;
		endtask

		task check_result(out_item_t got);
			out_item_t e;
			if (predicted.size() == 0) begin
				report("unexpected result", got.rx, 0);
				return;
			end
			e = predicted.pop_front();
			if (got.rx !== e.rx) report("rx", got.rx, e.rx);
			if (got.ry !== e.ry) report("ry", got.ry, e.ry);
			if (got.rz !== e.rz) report("rz", got.rz, e.rz);
			if (got.was_divided !== e.was_divided)
				report("was_divided", got.was_divided, e.was_divided);
			if (got.saturated !== e.saturated)
				report("saturated", got.saturated, e.saturated);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_item_t out_data;

	transform_scoreboard sb = new();
	bit calm = 0;      // in the last part of the run neither side idles
	int quiet_cycles = 0;

	always #2 clk = ~clk;

	homogeneous_point_transform #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// Both transfers are sampled at the rising edge; prediction happens the
	// moment an input transfer completes, so results are checked in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_input(in_data);
			if (out_valid && out_ready) sb.check_result(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Watchdog on cycles with no transfer at all.
	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: ready drops now and then for a random burst, never near the end.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end
			out_ready <= 1;
		end
	end

	// Sends one item and holds it until the transfer completes. Valid stays
	// high afterwards so the next item can follow without a gap.
	task send(in_item_t it);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_data <= it;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic in_item_t mk(logic [1:0] op, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z);
		in_item_t it;
		it = '0;
		it.opcode = op;
		it.vx = x;
		it.vy = y;
		it.vz = z;
		return it;
	endfunction

	function automatic in_item_t mk_load(int r, int c, logic signed [31:0] v);
		in_item_t it;
		it = '0;
		it.opcode = OP_LOAD;
		it.row_index = r[1:0];
		it.col_index = c[1:0];
		it.entry_value = v;
		it.vx = $urandom();
		return it;
	endfunction

	// Mostly modest values so results stay in range, with some extremes mixed in.
	function automatic logic signed [31:0] rand_val();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			2: return $urandom_range(0, 1) ? ONE : 32'sd0;
			default: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
		endcase
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		int pick;
		it = '0;
		it.row_index = 2'($urandom());
		it.col_index = 2'($urandom());
		it.entry_value = $urandom();
		it.vx = $urandom();
		it.vy = $urandom();
		it.vz = $urandom();
		pick = $urandom_range(0, 19);
		if (pick < 6) begin
			it.opcode = OP_LOAD;
			it.entry_value = rand_val();
		end else if (pick < 13) begin
			it.opcode = OP_POINT;
		end else if (pick < 19) begin
			it.opcode = OP_DIR;
		end else begin
			it.opcode = OP_UNUSED;
		end
		if (it.opcode != OP_UNUSED && $urandom_range(0, 3) != 0) begin
			it.vx = rand_val();
			it.vy = rand_val();
			it.vz = rand_val();
		end
		return it;
	endfunction

	initial begin
		int drain;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Directed: identity matrix first, w equal to one so no divide.
		send(mk(OP_POINT, ONE, -ONE, 32'sd3 <<< 16));
		send(mk(OP_DIR, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd0));
		send(mk(OP_POINT, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000));
		send(mk(OP_UNUSED, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
		// Bottom row zero gives w of zero: the divide is skipped.
		send(mk_load(3, 3, 32'sd0));
		send(mk(OP_POINT, ONE, ONE, ONE));
		// w of two: perspective divide halves each component.
		send(mk_load(3, 3, 32'sd2 <<< 16));
		send(mk(OP_POINT, 32'sd5 <<< 16, -(32'sd7 <<< 16), 32'sd1));
		send(mk(OP_DIR, 32'sd5 <<< 16, 32'sd7, -32'sd9));
		// Tiny w makes the quotients clip.
		send(mk_load(3, 3, 32'sd1));
		send(mk(OP_POINT, 32'sd100 <<< 16, -(32'sd100 <<< 16), 32'sd0));
		// Negative w and extreme entries in the upper rows.
		send(mk_load(3, 3, -(32'sd3 <<< 16)));
		send(mk_load(0, 0, 32'sh7fff_ffff));
		send(mk_load(1, 2, 32'sh8000_0000));
		send(mk_load(2, 3, 32'sh7fff_ffff));
		send(mk(OP_POINT, 32'sh7fff_ffff, -32'sd1, 32'sh8000_0000));
		send(mk(OP_DIR, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
		send(mk_load(3, 0, ONE));
		send(mk(OP_POINT, 32'sd0, 32'sd0, 32'sd0));

		// Hold off until every predicted result has come back.
		in_valid <= 0;
		@(negedge clk);
		while (sb.predicted.size() != 0) @(negedge clk);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - 60) calm = 1;
			send(rand_item());
		end
		in_valid <= 0;

		drain = 0;
		while (sb.predicted.size() != 0 && drain < 200000) begin
			@(negedge clk);
			drain++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.predicted.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
